// File: rtl/fat12_cluster_table_engine_defines.svh
// assertion macros used by the checker of the cluster table engine
`ifndef FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fct check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fct check failed");

`endif

// File: rtl/fct_pkg.sv
`timescale 1ns / 1ps

package fct_pkg;

    localparam int ENTRY_COUNT_DEF = 4096;

    localparam int ENTRY_W   = 12;
    localparam int CLUSTER_W = 12;
    localparam int LIMIT_W   = 13;
    localparam int TRACK_W   = 7;
    localparam int SECTOR_W  = 5;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FIND  = 2'd2;
    localparam logic [1:0] FUNC_COUNT = 2'd3;

    localparam logic [ENTRY_W-1:0] ENTRY0_INIT  = 12'hFF0;
    localparam logic [ENTRY_W-1:0] ENTRY1_INIT  = 12'hFFF;
    localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 12'hFFF;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2849;

    // floppy geometry: logical sector = cluster + 31, 18 sectors, 2 heads
    localparam logic [LIMIT_W-1:0] FIRST_DATA_SECTOR = 13'd31;
    localparam logic [5:0]         SECTORS_PER_TRACK = 6'd18;
    // ceil(2^17 / 36), exact for every logical sector below 32768
    localparam logic [11:0]        TRACK_RECIP       = 12'd3641;
    localparam int                 RECIP_SHIFT       = 17;

    typedef struct packed {
        logic [1:0]           func;
        logic [CLUSTER_W-1:0] cluster;
        logic [ENTRY_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]   entry_value;
        logic                 chain_end;
        logic                 found;
        logic [CLUSTER_W-1:0] free_index;
        logic [LIMIT_W-1:0]   free_clusters;
        logic [TRACK_W-1:0]   track;
        logic                 head;
        logic [SECTOR_W-1:0]  sector;
    } result_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_req;
        logic scan_done;
    } dp_status_t;

endpackage

// File: rtl/fat12_cluster_table_engine.sv
`timescale 1ns / 1ps

// FAT12 cluster table of ENTRY_COUNT 12-bit entries in one single-port-write,
// registered-read memory. A request is taken when start is high and busy low;
// its result shows on result with done high for exactly one cycle and must be
// taken then, since the receiver cannot stall the block. Read and write pass
// through the finish state before done, and the next request may start in the
// done cycle. Find-free and count-free walk the memory one entry per cycle
// through its single read port: find searches from entry 2 up to just below
// min(cluster_limit, ENTRY_COUNT) and stops once a free entry turns up, while
// count walks every entry from 0 below that bound. After reset a clearing pass
// writes the formatted table (entry 0 = 0xFF0, entry 1 = 0xFFF, rest zero)
// with busy held high; cluster_limit may be written whenever cfg_valid is high,
// since cfg_ready is always high, including during that pass.
module fat12_cluster_table_engine
#(
    parameter int ENTRY_COUNT = fct_pkg::ENTRY_COUNT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fct_pkg::req_t                req,
    output logic                         done,
    output fct_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fct_pkg::LIMIT_W-1:0]  cfg_data
);

    fct_pkg::ctrl_cmd_t  cmd;
    fct_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fct_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    fct_datapath
    #(
        .ENTRY_COUNT (ENTRY_COUNT)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

// File: rtl/fct_ctrl.sv
`timescale 1ns / 1ps

module fct_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fct_pkg::dp_status_t    status,
    output fct_pkg::ctrl_cmd_t     cmd,
    output logic                   busy,
    output logic                   done
);

    typedef enum logic [3:0]
    {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = status.scan_req ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIN);
        end
    end

    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.accept = (state_reg == ST_IDLE) && start;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FIN);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/fct_datapath.sv
`timescale 1ns / 1ps

module fct_datapath
#(
    parameter int ENTRY_COUNT = fct_pkg::ENTRY_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fct_pkg::ctrl_cmd_t                  cmd,
    output fct_pkg::dp_status_t                 status,
    input  fct_pkg::req_t                       req,
    input  logic                                cfg_we,
    input  logic [fct_pkg::LIMIT_W-1:0]         cfg_data,
    output fct_pkg::result_t                    result
);

    localparam int ADDR_W = $clog2(ENTRY_COUNT);
    localparam logic [fct_pkg::LIMIT_W-1:0] COUNT_L = fct_pkg::LIMIT_W'(ENTRY_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);
    localparam int RECIP_SHIFT_HI = fct_pkg::RECIP_SHIFT + fct_pkg::TRACK_W - 1;

    logic [fct_pkg::ENTRY_W-1:0] mem [ENTRY_COUNT];

    logic [fct_pkg::LIMIT_W-1:0]   limit_reg;
    logic [ADDR_W-1:0]             clr_idx_reg;
    logic [1:0]                    func_reg;
    logic                          in_range_reg;
    logic [fct_pkg::ENTRY_W-1:0]   value_reg;
    logic [fct_pkg::LIMIT_W-1:0]   lsec_reg;
    logic [fct_pkg::TRACK_W-1:0]   trk_reg;
    logic [fct_pkg::LIMIT_W-1:0]   scan_lim_reg;
    logic [fct_pkg::LIMIT_W-1:0]   scan_idx_reg;
    logic                          p_valid_reg;
    logic [fct_pkg::CLUSTER_W-1:0] p_idx_reg;
    logic                          found_reg;
    logic [fct_pkg::CLUSTER_W-1:0] free_idx_reg;
    logic [fct_pkg::LIMIT_W-1:0]   count_reg;
    logic [fct_pkg::ENTRY_W-1:0]   rd_data_reg;
    fct_pkg::result_t              result_reg;
    fct_pkg::result_t              result_next;

    logic                          in_range;
    logic [fct_pkg::LIMIT_W-1:0]   lim;
    logic [fct_pkg::LIMIT_W-1:0]   lsec;
    logic [23:0]                   prod;
    logic                          issue;
    logic                          is_find;
    logic                          mem_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [fct_pkg::ENTRY_W-1:0]   wr_data;
    logic [fct_pkg::ENTRY_W-1:0]   init_data;
    logic [ADDR_W-1:0]             rd_addr;
    logic [fct_pkg::LIMIT_W-1:0]   trk_x36;
    logic [fct_pkg::LIMIT_W-1:0]   rem_full;
    logic [5:0]                    rem;
    logic                          head;
    logic [5:0]                    sec0;
    logic [fct_pkg::ENTRY_W-1:0]   entry;

    assign in_range = ({1'b0, req.cluster} < COUNT_L);
    assign lim      = (limit_reg > COUNT_L) ? COUNT_L : limit_reg;
    assign lsec     = {1'b0, req.cluster} + fct_pkg::FIRST_DATA_SECTOR;
    assign prod     = 24'(lsec) * 24'(fct_pkg::TRACK_RECIP);
    assign is_find  = (func_reg == fct_pkg::FUNC_FIND);

    // find stops issuing once a free entry has been seen
    assign issue = cmd.scan && (scan_idx_reg < scan_lim_reg) && !(is_find && found_reg);

    assign status.clear_last = (clr_idx_reg == LAST_ADDR);
    assign status.scan_req   = (req.func == fct_pkg::FUNC_FIND) ||
                               (req.func == fct_pkg::FUNC_COUNT);
    assign status.scan_done  = (is_find && found_reg) ||
                               ((scan_idx_reg >= scan_lim_reg) && !p_valid_reg);

    // formatted table contents written by the clearing pass
    always_comb
    begin
        if (clr_idx_reg == ADDR_W'(0))
        begin
            init_data = fct_pkg::ENTRY0_INIT;
        end
        else if (clr_idx_reg == ADDR_W'(1))
        begin
            init_data = fct_pkg::ENTRY1_INIT;
        end
        else
        begin
            init_data = '0;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = init_data;
        end
        else
        begin
            mem_we  = cmd.accept && (req.func == fct_pkg::FUNC_WRITE) && in_range;
            wr_addr = req.cluster[ADDR_W-1:0];
            wr_data = req.value;
        end
    end

    assign rd_addr = cmd.scan ? scan_idx_reg[ADDR_W-1:0] : req.cluster[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= fct_pkg::LIMIT_RESET;
            clr_idx_reg  <= '0;
            p_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
            scan_lim_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_idx_reg <= ADDR_W'(clr_idx_reg + 1'b1);
            end
            if (cmd.accept)
            begin
                scan_idx_reg <= (req.func == fct_pkg::FUNC_FIND) ? 13'd2 : 13'd0;
                scan_lim_reg <= lim;
                p_valid_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                p_valid_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= fct_pkg::LIMIT_W'(scan_idx_reg + 1'b1);
                end
                if (p_valid_reg && (rd_data_reg == '0) && is_find)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg     <= req.func;
            in_range_reg <= in_range;
            value_reg    <= req.value;
            lsec_reg     <= lsec;
            trk_reg      <= prod[RECIP_SHIFT_HI:fct_pkg::RECIP_SHIFT];
            count_reg    <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                p_idx_reg <= scan_idx_reg[fct_pkg::CLUSTER_W-1:0];
            end
            if (p_valid_reg && (rd_data_reg == '0))
            begin
                count_reg <= fct_pkg::LIMIT_W'(count_reg + 1'b1);
                if (!found_reg)
                begin
                    free_idx_reg <= p_idx_reg;
                end
            end
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    // remainder by 36 from the registered quotient
    assign trk_x36  = ({6'd0, trk_reg} << 5) + ({6'd0, trk_reg} << 2);
    assign rem_full = lsec_reg - trk_x36;
    assign rem      = rem_full[5:0];
    assign head     = (rem >= fct_pkg::SECTORS_PER_TRACK);
    assign sec0     = head ? (rem - fct_pkg::SECTORS_PER_TRACK) : rem;

    always_comb
    begin
        case (func_reg)
            fct_pkg::FUNC_READ:  entry = in_range_reg ? rd_data_reg : '0;
            fct_pkg::FUNC_WRITE: entry = value_reg;
            default:             entry = '0;
        endcase
    end

    always_comb
    begin
        result_next.entry_value   = entry;
        result_next.chain_end     = (entry == fct_pkg::END_OF_CHAIN);
        result_next.found         = is_find && found_reg;
        result_next.free_index    = (is_find && found_reg) ? free_idx_reg : '0;
        result_next.free_clusters = (func_reg == fct_pkg::FUNC_COUNT) ? count_reg : '0;
        result_next.track         = trk_reg;
        result_next.head          = head;
        result_next.sector        = fct_pkg::SECTOR_W'(sec0) + 5'd1;
    end

    assign result = result_reg;

endmodule

// File: rtl/fct_checker.sv
`timescale 1ns / 1ps
`include "fat12_cluster_table_engine_defines.svh"

module fct_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input fct_pkg::result_t result
);

    // a result beat only comes out once the block is free again
    `FCT_ASSERT_SAME(a_done_idle, done, !busy)
    // every result beat closes a busy stretch
    `FCT_ASSERT_SAME(a_done_after_busy, done, $past(busy))
    // an accepted request makes the block busy on the next cycle
    `FCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // result beats never come back to back
    `FCT_ASSERT_NEXT(a_single_beat, done, !done)
    // chain end flag agrees with the entry shown
    `FCT_ASSERT_SAME(a_chain_end, done, result.chain_end == (result.entry_value == fct_pkg::END_OF_CHAIN))

endmodule

bind fat12_cluster_table_engine fct_checker u_fct_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH   = fct_pkg::ENTRY_COUNT_DEF;
    localparam int SECTORS_PER_CYL = 2 * int'(fct_pkg::SECTORS_PER_TRACK);

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    fct_pkg::req_t               req;
    logic                        done;
    fct_pkg::result_t            result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [fct_pkg::LIMIT_W-1:0] cfg_data;

    // shadow copy of the cluster table and the limit register
    logic [fct_pkg::ENTRY_W-1:0] fat_mem [TABLE_DEPTH];
    logic [fct_pkg::LIMIT_W-1:0] limit_shadow;
    fct_pkg::result_t            pending_results[$];
    int                          fail_count = 0;
    fct_pkg::result_t            want;

    fat12_cluster_table_engine #(
        .ENTRY_COUNT(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int scan_bound();
        int lim;
        lim = int'(limit_shadow);
        if (lim > TABLE_DEPTH)
            lim = TABLE_DEPTH;
        return lim;
    endfunction

    // applies one request to the shadow table and returns the result it gives
    function automatic fct_pkg::result_t predict_table_result(fct_pkg::req_t r);
        fct_pkg::result_t o;
        int               lim;
        int               lsec;
        int               free_cnt;
        o = '0;
        lim = scan_bound();
        free_cnt = 0;
        case (r.func)
            fct_pkg::FUNC_READ:
            begin
                if (int'(r.cluster) < TABLE_DEPTH)
                    o.entry_value = fat_mem[r.cluster];
            end
            fct_pkg::FUNC_WRITE:
            begin
                if (int'(r.cluster) < TABLE_DEPTH)
                    fat_mem[r.cluster] = r.value;
                o.entry_value = r.value;
            end
            fct_pkg::FUNC_FIND:
            begin
                for (int i = 2; i < lim; i++)
                begin
                    if (fat_mem[i] == '0)
                    begin
                        o.found = 1'b1;
                        o.free_index = fct_pkg::CLUSTER_W'(i);
                        break;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < lim; i++)
                    if (fat_mem[i] == '0)
                        free_cnt++;
                o.free_clusters = fct_pkg::LIMIT_W'(free_cnt);
            end
        endcase
        o.chain_end = (o.entry_value == fct_pkg::END_OF_CHAIN);
        lsec = int'(r.cluster) + int'(fct_pkg::FIRST_DATA_SECTOR);
        o.track = fct_pkg::TRACK_W'(lsec / SECTORS_PER_CYL);
        o.head = 1'((lsec % SECTORS_PER_CYL) / int'(fct_pkg::SECTORS_PER_TRACK));
        o.sector = fct_pkg::SECTOR_W'(lsec % int'(fct_pkg::SECTORS_PER_TRACK) + 1);
        return o;
    endfunction

    // config beats, result checks and request predictions, all on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                limit_shadow = cfg_data;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.entry_value !== want.entry_value
                        || result.chain_end !== want.chain_end
                        || result.found !== want.found
                        || result.free_index !== want.free_index
                        || result.free_clusters !== want.free_clusters
                        || result.track !== want.track
                        || result.head !== want.head
                        || result.sector !== want.sector)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch entry/end/found/idx/free/trk/hd/sec", $realtime);
                            $display("  expected %h %b %b %h %h %h %b %h", want.entry_value,
                                     want.chain_end, want.found, want.free_index,
                                     want.free_clusters, want.track, want.head, want.sector);
                            $display("  actual   %h %b %b %h %h %h %b %h", result.entry_value,
                                     result.chain_end, result.found, result.free_index,
                                     result.free_clusters, result.track, result.head,
                                     result.sector);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(predict_table_result(req));
        end
    end

    function automatic fct_pkg::req_t make_req(logic [1:0] f,
                                               logic [fct_pkg::CLUSTER_W-1:0] c,
                                               logic [fct_pkg::ENTRY_W-1:0] v);
        fct_pkg::req_t r;
        r.func = f;
        r.cluster = c;
        r.value = v;
        return r;
    endfunction

    // holds start low for the requested gap, if any, then keeps the beat up until it is taken
    task automatic send_request(input fct_pkg::req_t r, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [fct_pkg::LIMIT_W-1:0] lim);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic fct_pkg::req_t random_request();
        fct_pkg::req_t r;
        int            eff;
        int            sel;
        eff = scan_bound();
        if (eff < 1)
            eff = 1;
        sel = $urandom_range(99);
        if (sel < 35)
            r.func = fct_pkg::FUNC_READ;
        else if (sel < 75)
            r.func = fct_pkg::FUNC_WRITE;
        else if (sel < 87)
            r.func = fct_pkg::FUNC_FIND;
        else
            r.func = fct_pkg::FUNC_COUNT;
        // keep most traffic inside the scanned region so finds and counts move
        sel = $urandom_range(99);
        if (sel < 60)
            r.cluster = fct_pkg::CLUSTER_W'($urandom_range(0, eff - 1));
        else if (sel < 85)
            r.cluster = fct_pkg::CLUSTER_W'($urandom_range(0, TABLE_DEPTH - 1));
        else
            r.cluster = fct_pkg::CLUSTER_W'($urandom_range(0, 7));
        sel = $urandom_range(99);
        if (sel < 35)
            r.value = '0;
        else if (sel < 50)
            r.value = fct_pkg::END_OF_CHAIN;
        else
            r.value = fct_pkg::ENTRY_W'($urandom_range(0, 4095));
        return r;
    endfunction

    task automatic test_formatted_table();
        send_request(make_req(fct_pkg::FUNC_READ, 12'd0, 12'hFFF), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd1, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd2, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd4095, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_FIND, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
    endtask

    task automatic test_entry_updates();
        send_request(make_req(fct_pkg::FUNC_WRITE, 12'd2, 12'h003), 0);
        send_request(make_req(fct_pkg::FUNC_WRITE, 12'd3, 12'hFFF), 0);
        send_request(make_req(fct_pkg::FUNC_FIND, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_WRITE, 12'd4095, 12'hFFF), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd4095, 12'd0), 0);
        // reserved entries behave like any other
        send_request(make_req(fct_pkg::FUNC_WRITE, 12'd0, 12'h000), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_WRITE, 12'd1, 12'hABC), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd1, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
    endtask

    task automatic test_limit_extremes();
        // limit above the table clamps to the table size
        write_limit(13'd8191);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
        write_limit(13'd4096);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_FIND, 12'd0, 12'd0), 0);
        // entry 2 is in use here, so the search comes up empty
        write_limit(13'd3);
        send_request(make_req(fct_pkg::FUNC_FIND, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
        write_limit(13'd2);
        send_request(make_req(fct_pkg::FUNC_FIND, 12'd0, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
        write_limit(13'd0);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
        write_limit(13'd1);
        send_request(make_req(fct_pkg::FUNC_COUNT, 12'd0, 12'd0), 0);
    endtask

    task automatic test_sector_geometry();
        send_request(make_req(fct_pkg::FUNC_READ, 12'd5, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd22, 12'd0), 0);
        send_request(make_req(fct_pkg::FUNC_READ, 12'd4094, 12'd0), 0);
    endtask

    task automatic test_traffic(input int n_items, input int idle_pct);
        int gap;
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                write_limit($urandom_range(1) ? 13'd4096 : 13'd8191);
            else if (pick == 1)
                write_limit(fct_pkg::LIMIT_W'($urandom_range(0, 2)));
            else
                write_limit(fct_pkg::LIMIT_W'($urandom_range(3, 256)));
            for (int k = 0; k < 100 && sent < n_items; k++)
            begin
                gap = 0;
                while (gap < 16 && $urandom_range(99) < idle_pct)
                    gap++;
                send_request(random_request(), gap);
                sent++;
            end
        end
    endtask

    initial
    begin
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        foreach (fat_mem[i])
            fat_mem[i] = '0;
        fat_mem[0] = fct_pkg::ENTRY0_INIT;
        fat_mem[1] = fct_pkg::ENTRY1_INIT;
        limit_shadow = fct_pkg::LIMIT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_formatted_table();
        test_entry_updates();
        test_limit_extremes();
        test_sector_geometry();
        test_traffic(510, 12);
        test_traffic(510, 62);
        test_traffic(510, 0);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_ctrl.sv
rtl/fct_datapath.sv
rtl/fat12_cluster_table_engine.sv
rtl/fct_checker.sv
tb/tb_top.sv
